// File: rtl/core/gsdg_pkg.sv
`default_nettype none

package gsdg_pkg;

  localparam int PALETTE_ENTRIES = 16;
  localparam int LAST            = PALETTE_ENTRIES - 1;
  localparam int IDX_W           = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int PTR_W           = IDX_W + 2;
  localparam int SEARCH_STEPS    = $clog2(PALETTE_ENTRIES) + 1;
  localparam int STAGES          = SEARCH_STEPS + 2;
  localparam int CFG_INDEX_W     = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PALETTE_LOW  = 2'd0,
    REG_PALETTE_HIGH = 2'd1
  } cfg_reg_t;

  localparam logic [63:0] PALETTE_LOW_RESET  = 64'h7766_5544_3322_1100;
  localparam logic [63:0] PALETTE_HIGH_RESET = 64'hFFEE_DDCC_BBAA_9988;

  localparam logic [7:0] GLYPH_BLANK  = 8'd32;
  localparam logic [7:0] GLYPH_LIGHT  = 8'd176;
  localparam logic [7:0] GLYPH_MEDIUM = 8'd177;
  localparam logic [7:0] GLYPH_DARK   = 8'd178;

  typedef logic [PALETTE_ENTRIES-1:0][7:0] palette_t;

  typedef struct packed {
    logic [7:0]  shade;
    logic [11:0] x_coord;
    logic [11:0] y_coord;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  glyph;
    logic [7:0]  attribute;
    logic [11:0] out_x;
    logic [11:0] out_y;
  } out_item_t;

  // binary search state carried down the probe stages
  typedef struct packed {
    in_item_t                 item;
    logic signed [PTR_W-1:0]  lo;
    logic signed [PTR_W-1:0]  hi;
    logic                     exact;
    logic [IDX_W-1:0]         exact_idx;
  } search_t;

  // bracket and differences, ready for the band compares
  typedef struct packed {
    logic [11:0]       x_coord;
    logic [11:0]       y_coord;
    logic              forced;
    logic [3:0]        forced_nib;
    logic [3:0]        lo_nib;
    logic [3:0]        hi_nib;
    logic signed [9:0] d;
    logic signed [9:0] r;
  } bracket_t;

endpackage

`default_nettype wire

// File: rtl/core/gsdg_search_step.sv
`default_nettype none

module gsdg_search_step (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  gsdg_pkg::search_t in_s,
  input  gsdg_pkg::palette_t palette,
  output logic              out_valid,
  output gsdg_pkg::search_t out_s
);
  import gsdg_pkg::*;

  logic                    active;
  logic signed [PTR_W:0]   sum;
  logic [IDX_W-1:0]        mid;
  logic signed [PTR_W-1:0] mid_p;
  logic [7:0]              probe;
  search_t                 nxt;

  always_comb begin
    nxt    = in_s;
    active = !in_s.exact && (in_s.lo <= in_s.hi);
    sum    = {in_s.lo[PTR_W-1], in_s.lo} + {in_s.hi[PTR_W-1], in_s.hi};
    mid    = sum[IDX_W:1];
    mid_p  = signed'(PTR_W'(mid));
    probe  = palette[mid];
    if (active) begin
      if (in_s.item.shade < probe) begin
        nxt.hi = PTR_W'(mid_p - 1);
      end else if (in_s.item.shade > probe) begin
        nxt.lo = PTR_W'(mid_p + 1);
      end else begin
        nxt.exact     = 1'b1;
        nxt.exact_idx = mid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_s <= nxt;
    end
  end

`ifndef SYNTHESIS
  a_bracket_closes: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_s.exact |-> (out_s.lo <= out_s.hi + 1))
    else $error("search bracket crossed by more than one");
`endif

endmodule

`default_nettype wire

// File: rtl/core/gsdg_classify.sv
`default_nettype none

module gsdg_classify (
  input  logic                clk,
  input  logic                rst,
  input  logic                en_a,
  input  logic                en_b,
  input  logic                in_valid,
  input  gsdg_pkg::search_t   in_s,
  input  gsdg_pkg::palette_t  palette,
  output logic                a_valid,
  output logic                out_valid,
  output gsdg_pkg::out_item_t out_data
);
  import gsdg_pkg::*;

  // stage A: clamp, pick bracket, subtract
  logic             below;
  logic             above;
  logic [IDX_W-1:0] lo_idx;
  logic [IDX_W-1:0] hi_idx;
  logic [7:0]       e_lo;
  logic [7:0]       e_hi;
  bracket_t         a_next;
  bracket_t         a;

  always_comb begin
    below  = !in_s.exact && (in_s.hi < 0);
    above  = !in_s.exact && (in_s.lo > LAST);
    lo_idx = in_s.hi[IDX_W-1:0];
    hi_idx = in_s.lo[IDX_W-1:0];
    e_lo   = palette[lo_idx];
    e_hi   = palette[hi_idx];
    a_next.x_coord = in_s.item.x_coord;
    a_next.y_coord = in_s.item.y_coord;
    a_next.forced  = in_s.exact || below || above;
    if (in_s.exact) begin
      a_next.forced_nib = 4'(in_s.exact_idx);
    end else if (below) begin
      a_next.forced_nib = 4'd0;
    end else begin
      a_next.forced_nib = 4'(LAST);
    end
    a_next.lo_nib = 4'(lo_idx);
    a_next.hi_nib = 4'(hi_idx);
    a_next.d = $signed({2'b00, in_s.item.shade}) - $signed({2'b00, e_lo});
    a_next.r = $signed({2'b00, e_hi}) - $signed({2'b00, e_lo});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en_a) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      a <= a_next;
    end
  end

  // stage B: band compares, f = d / r
  logic signed [17:0] d_x;
  logic signed [17:0] r_x;
  logic signed [17:0] d8;
  logic signed [17:0] d125;
  logic signed [17:0] r47;
  logic signed [17:0] r5;
  logic signed [17:0] r7;
  out_item_t          b_next;

  always_comb begin
    d_x  = 18'(a.d);
    r_x  = 18'(a.r);
    d8   = d_x <<< 3;
    d125 = 18'(d_x * 18'sd125);
    r47  = 18'(r_x * 18'sd47);
    r5   = 18'(r_x * 18'sd5);
    r7   = 18'(r_x * 18'sd7);
    b_next.out_x     = a.x_coord;
    b_next.out_y     = a.y_coord;
    b_next.glyph     = GLYPH_BLANK;
    b_next.attribute = {a.lo_nib, a.hi_nib};
    if (a.forced) begin
      b_next.attribute = {a.forced_nib, 4'd0};
    end else if (a.r <= 0 || a.d <= 0 || d8 < r_x) begin
      b_next.attribute = {a.lo_nib, 4'd0};
    end else if (a.d >= a.r) begin
      b_next.attribute = {a.hi_nib, 4'd0};
    end else if (d125 < r47) begin
      b_next.glyph = GLYPH_LIGHT;
    end else if (d8 < r5) begin
      b_next.glyph = GLYPH_MEDIUM;
    end else if (d8 < r7) begin
      b_next.glyph = GLYPH_DARK;
    end else begin
      b_next.attribute = {a.hi_nib, 4'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en_b) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      out_data <= b_next;
    end
  end

`ifndef SYNTHESIS
  a_shade_pair: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.glyph != GLYPH_BLANK) |->
      (out_data.attribute[3:0] == out_data.attribute[7:4] + 4'd1))
    else $error("shade glyph without adjacent colour pair");

  a_blank_bg_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.glyph == GLYPH_BLANK) |-> (out_data.attribute[3:0] == 4'd0))
    else $error("blank glyph with foreground set");
`endif

endmodule

`default_nettype wire

// File: rtl/core/grey_shade_to_dither_glyph.sv
`default_nettype none

// channel   direction  handshake                payload
// in        in         in_valid / in_stall      in_data  (shade, x_coord, y_coord)
// out       out        out_valid / out_stall    out_data (glyph, attribute, out_x, out_y)
// cfg       in         cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One item per clock while out_stall is low, through the stages:
// one binary search probe per stage, then bracket/subtract, then band compares.
// Synchronous reset clears the valid bits and loads the default grey ramp.
// A stall fills bubbles first and holds each full stage; nothing lost or repeated.
// cfg_ready is always high; writes to indexes beyond the list are dropped.

module grey_shade_to_dither_glyph (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  gsdg_pkg::in_item_t                    in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output gsdg_pkg::out_item_t                   out_data,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [gsdg_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [63:0]                           cfg_data
);
  import gsdg_pkg::*;

  logic [63:0]         palette_low_half;
  logic [63:0]         palette_high_half;
  palette_t            palette;
  search_t             search_s [SEARCH_STEPS+1];
  logic [SEARCH_STEPS:0] search_v;
  logic [STAGES-1:0]   stage_valid;
  logic [STAGES-1:0]   stage_ready;
  logic                a_valid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      palette_low_half  <= PALETTE_LOW_RESET;
      palette_high_half <= PALETTE_HIGH_RESET;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_PALETTE_LOW:  palette_low_half  <= cfg_data;
        REG_PALETTE_HIGH: palette_high_half <= cfg_data;
        default: ;
      endcase
    end
  end

  for (genvar k = 0; k < PALETTE_ENTRIES; k++) begin : g_pal
    if (k < 8) begin : g_lo
      assign palette[k] = palette_low_half[8*k +: 8];
    end else begin : g_hi
      assign palette[k] = palette_high_half[8*(k-8) +: 8];
    end
  end

  always_comb begin
    search_s[0].item      = in_data;
    search_s[0].lo        = '0;
    search_s[0].hi        = PTR_W'(LAST);
    search_s[0].exact     = 1'b0;
    search_s[0].exact_idx = '0;
  end
  assign search_v[0] = in_valid;

  for (genvar i = 0; i < SEARCH_STEPS; i++) begin : g_step
    gsdg_search_step u_step (
      .clk       (clk),
      .rst       (rst),
      .en        (stage_ready[i]),
      .in_valid  (search_v[i]),
      .in_s      (search_s[i]),
      .palette   (palette),
      .out_valid (search_v[i+1]),
      .out_s     (search_s[i+1])
    );
  end

  gsdg_classify u_classify (
    .clk       (clk),
    .rst       (rst),
    .en_a      (stage_ready[SEARCH_STEPS]),
    .en_b      (stage_ready[SEARCH_STEPS+1]),
    .in_valid  (search_v[SEARCH_STEPS]),
    .in_s      (search_s[SEARCH_STEPS]),
    .palette   (palette),
    .a_valid   (a_valid),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  assign stage_valid = {out_valid, a_valid, search_v[SEARCH_STEPS:1]};

  // a stage loads when empty or when the one after it moves
  always_comb begin
    stage_ready[STAGES-1] = !out_valid || !out_stall;
    for (int k = STAGES - 2; k >= 0; k--) begin
      stage_ready[k] = !stage_valid[k] || stage_ready[k+1];
    end
  end

  assign in_stall = !stage_ready[0];

`ifndef SYNTHESIS
  a_full_stalls_input: assert property (@(posedge clk) disable iff (rst)
    (&stage_valid) && out_stall |-> in_stall)
    else $error("input taken while every stage is held");

  a_cfg_low_lands: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready && (cfg_index == REG_PALETTE_LOW) |=>
      (palette_low_half == $past(cfg_data)))
    else $error("palette low half write lost");

  a_bubble_moves: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output stage");
`endif

endmodule

`default_nettype wire

// File: test/dither_glyph_checker.sv
module dither_glyph_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  gsdg_pkg::in_item_t                 in_data,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  gsdg_pkg::out_item_t                out_data,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [gsdg_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [63:0]                        cfg_data,
  output int                                 mismatches,
  output int                                 pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import gsdg_pkg::*;

  logic [127:0] palette_bits = {PALETTE_HIGH_RESET, PALETTE_LOW_RESET};
  out_item_t    cells_due[$];
  int           fails = 0;

  // bracket the shade by binary search, then pick the band of the fraction
  function automatic out_item_t dither_cell(input in_item_t px, input palette_t pal);
    int        s;
    int        lo;
    int        hi;
    int        mid;
    int        e;
    int        d;
    int        r;
    int        lo_idx;
    int        hi_idx;
    int        hit_idx;
    bit        hit;
    out_item_t res;
    s = px.shade;
    lo = 0;
    hi = LAST;
    hit = 1'b0;
    hit_idx = 0;
    while (lo <= hi && !hit) begin
      mid = (lo + hi) / 2;
      e = pal[mid];
      if (s < e) begin
        hi = mid - 1;
      end else if (s > e) begin
        lo = mid + 1;
      end else begin
        hit = 1'b1;
        hit_idx = mid;
      end
    end
    // outside the palette span: clamp to the end entry
    if (!hit && hi < 0) begin
      hit = 1'b1;
      hit_idx = 0;
    end else if (!hit && lo > LAST) begin
      hit = 1'b1;
      hit_idx = LAST;
    end
    res.out_x = px.x_coord;
    res.out_y = px.y_coord;
    res.glyph = GLYPH_BLANK;
    if (hit) begin
      res.attribute = {hit_idx[3:0], 4'h0};
    end else begin
      lo_idx = hi;
      hi_idx = lo;
      d = s - int'(pal[lo_idx]);
      r = int'(pal[hi_idx]) - int'(pal[lo_idx]);
      res.attribute = {lo_idx[3:0], hi_idx[3:0]};
      if (r <= 0 || d <= 0 || 8 * d < r) begin
        res.attribute = {lo_idx[3:0], 4'h0};
      end else if (d >= r) begin
        res.attribute = {hi_idx[3:0], 4'h0};
      end else if (125 * d < 47 * r) begin
        res.glyph = GLYPH_LIGHT;
      end else if (8 * d < 5 * r) begin
        res.glyph = GLYPH_MEDIUM;
      end else if (8 * d < 7 * r) begin
        res.glyph = GLYPH_DARK;
      end else begin
        res.attribute = {hi_idx[3:0], 4'h0};
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    fails++;
    if (fails <= 100) $display("%0t: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      palette_bits = {PALETTE_HIGH_RESET, PALETTE_LOW_RESET};
      cells_due.delete();
    end else begin
      if (in_valid && !in_stall) cells_due.push_back(dither_cell(in_data, palette_bits));
      if (out_valid && !out_stall) begin
        if (cells_due.size() == 0) begin
          report_mismatch($sformatf("unexpected item: glyph %0d attribute %02h at (%0d,%0d)",
                                    out_data.glyph, out_data.attribute,
                                    out_data.out_x, out_data.out_y));
        end else begin
          want = cells_due.pop_front();
          if (out_data.glyph !== want.glyph)
            report_mismatch($sformatf("glyph at (%0d,%0d): got %0d, expected %0d",
                                      want.out_x, want.out_y, out_data.glyph, want.glyph));
          if (out_data.attribute !== want.attribute)
            report_mismatch($sformatf("attribute at (%0d,%0d): got %02h, expected %02h",
                                      want.out_x, want.out_y, out_data.attribute,
                                      want.attribute));
          if (out_data.out_x !== want.out_x)
            report_mismatch($sformatf("out_x: got %0d, expected %0d",
                                      out_data.out_x, want.out_x));
          if (out_data.out_y !== want.out_y)
            report_mismatch($sformatf("out_y: got %0d, expected %0d",
                                      out_data.out_y, want.out_y));
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_PALETTE_LOW) palette_bits[63:0] = cfg_data;
        else if (cfg_index == REG_PALETTE_HIGH) palette_bits[127:64] = cfg_data;
      end
    end
    mismatches <= fails;
    pending <= cells_due.size();
  end

endmodule

// File: test/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gsdg_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int RANDOM_PER_PHASE = 180;

  typedef enum int {FLOW, LIGHT_STALL, HEAVY_STALL, PERIODIC} stall_mode_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  in_item_t               in_data = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_item_t              out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [63:0]            cfg_data = '0;

  int                     mismatches;
  int                     pending;
  int unsigned            cycles = 0;
  logic [127:0]           cur_pal = {PALETTE_HIGH_RESET, PALETTE_LOW_RESET};
  stall_mode_t            stall_mode = FLOW;
  int                     stall_left = 0;
  int unsigned            stall_tick = 0;

  grey_shade_to_dither_glyph dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  dither_glyph_checker chk (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver back-pressure, switching to a random mode whenever stall_left runs out
  always @(posedge clk) begin
    stall_tick <= stall_tick + 1;
    if (stall_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(24, 240);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      FLOW:        out_stall <= 1'b0;
      LIGHT_STALL: out_stall <= ($urandom_range(0, 3) == 0);
      HEAVY_STALL: out_stall <= ($urandom_range(0, 9) < 7);
      default:     out_stall <= ((stall_tick % 7) < 3);
    endcase
  end

  task automatic send(input in_item_t px);
    in_data <= px;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic settle();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (STAGES + 2) @(posedge clk);
  endtask

  task automatic program_palette(input logic [127:0] p, input bit spare);
    settle();
    // writes to unused indexes must leave the palette alone
    if (spare) begin
      write_reg(REG_SPARE_A, {$urandom, $urandom});
      write_reg(REG_SPARE_B, {$urandom, $urandom});
    end
    write_reg(REG_PALETTE_LOW, p[63:0]);
    write_reg(REG_PALETTE_HIGH, p[127:64]);
    cfg_valid <= 1'b0;
    cur_pal = p;
  endtask

  function automatic logic [127:0] ramp(input int base, input int step);
    logic [127:0] p;
    for (int k = 0; k < PALETTE_ENTRIES; k++) p[8*k +: 8] = 8'(base + step * k);
    return p;
  endfunction

  function automatic logic [127:0] random_palette(input int lo_v, input int hi_v,
                                                  input bit ordered);
    byte unsigned vals[$];
    logic [127:0] p;
    for (int k = 0; k < PALETTE_ENTRIES; k++) vals.push_back(8'($urandom_range(lo_v, hi_v)));
    if (ordered) vals.sort();
    for (int k = 0; k < PALETTE_ENTRIES; k++) p[8*k +: 8] = vals[k];
    return p;
  endfunction

  function automatic logic [11:0] random_coord();
    if ($urandom_range(0, 15) == 0) return $urandom_range(0, 1) ? 12'hFFF : 12'h000;
    return 12'($urandom_range(0, 4095));
  endfunction

  // shades cluster on and around palette entries so every band is reached
  function automatic in_item_t random_pixel();
    in_item_t px;
    int       k;
    int       v;
    k = $urandom_range(0, LAST);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = int'(cur_pal[8*k +: 8]);
      4, 5:       v = int'(cur_pal[8*k +: 8]) + int'($urandom_range(0, 6)) - 3;
      default:    v = int'($urandom_range(0, 255));
    endcase
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    px.shade = 8'(v);
    px.x_coord = random_coord();
    px.y_coord = random_coord();
    return px;
  endfunction

  task automatic random_run(input int n, input bit steady);
    int left;
    int burst;
    int gap;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(1, 48);
      while (burst > 0 && left > 0) begin
        send(random_pixel());
        burst--;
        left--;
      end
      gap = steady ? 0 : (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9));
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    logic [127:0] p;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // default ramp: both ends, then one bracket swept through every band
    send({8'd0, 12'h000, 12'hFFF});
    send({8'd255, 12'hFFF, 12'h000});
    for (int s = 16; s <= 34; s++) send({8'(s), 12'(s * 37), 12'(4095 - s * 101)});
    random_run(RANDOM_PER_PHASE, 1'b0);

    // narrow span: below, above, and a fraction of exactly three eighths
    program_palette(ramp(40, 8), 1'b0);
    send({8'd0, 12'h155, 12'hAAA});
    send({8'd255, 12'hAAA, 12'h555});
    send({8'd43, 12'hFFF, 12'hFFF});
    random_run(RANDOM_PER_PHASE, 1'b0);

    p = random_palette(0, 255, 1'b1);
    p[7:0] = 8'h00;
    p[127:120] = 8'hFF;
    program_palette(p, 1'b0);
    random_run(RANDOM_PER_PHASE, 1'b1);

    program_palette('0, 1'b0);
    random_run(RANDOM_PER_PHASE, 1'b0);

    program_palette('1, 1'b0);
    random_run(RANDOM_PER_PHASE, 1'b0);

    program_palette(random_palette(0, 255, 1'b0), 1'b0);
    random_run(RANDOM_PER_PHASE, 1'b0);

    program_palette(random_palette(60, 90, 1'b1), 1'b1);
    random_run(RANDOM_PER_PHASE, 1'b0);

    settle();
    if (mismatches == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
